FILE: rtl/i2da_pkg.sv
`default_nettype none

package i2da_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Double dabble: a BCD digit at or above five gets three added before the shift
  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADD   = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic digit_shift;
  } dab_ctl_t;

  // Decimal digits of 2^(width-1), the largest magnitude
  function automatic int digit_slots(input int width);
    return ((width - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/int_to_decimal_ascii.sv
`default_nettype none

// Signed integer to decimal ASCII text. Each input transaction carries one
// two's complement integer of DATA_WIDTH bits (the low bits of in_tdata); the
// block answers with its decimal text, one character per output transaction,
// most significant first: a leading '-' for negative values, no leading zeros,
// a single '0' for zero, and out_tlast high on the final character. The most
// negative value converts correctly. Work is one number at a time: in_tready is
// high only while the converter is idle. An item is loaded, run through the
// bit-serial double dabble unit (one magnitude bit per cycle), handed over,
// stripped of leading zero slots (ND digit slots, ND = 10 at 32 bits; at least
// one digit stays), then sent one character at a time as out_tready allows.
// The last character sits in an output register, so the next number is
// accepted while it still waits on out_tready.
module int_to_decimal_ascii #(
  parameter  int DATA_WIDTH = i2da_pkg::DATA_WIDTH_DEF,
  localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  input  wire  [IN_W-1:0] in_tdata,   // value [DATA_WIDTH-1:0], zero fill above
  output logic            out_tvalid,
  input  wire             out_tready,
  output logic [7:0]      out_tdata,  // char_code [7:0]
  output logic            out_tlast
);

  localparam int ND = i2da_pkg::digit_slots(DATA_WIDTH);
  localparam int LW = $clog2(ND + 1);

  i2da_pkg::state_t   state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [LW-1:0]      left_r, left_nxt;   // digit slots still in the BCD register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  i2da_pkg::dab_ctl_t dab_ctl;
  logic               dab_busy;
  logic [3:0]         top_digit;

  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] mag;
  logic                  in_fire;
  logic                  out_free;

  // Magnitude as unsigned: the most negative value wraps to 2^(DATA_WIDTH-1)
  assign value = in_tdata[DATA_WIDTH-1:0];
  assign mag   = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;

  assign in_tready = (state_r == i2da_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // Output register can take a new character this cycle
  assign out_free  = !out_valid_r || out_tready;

  i2da_dabble #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dab_ctl),
    .mag       (mag),
    .busy      (dab_busy),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt           = state_r;
    neg_nxt             = neg_r;
    left_nxt            = left_r;
    out_valid_nxt       = out_valid_r && !out_tready;
    out_char_nxt        = out_char_r;
    out_last_nxt        = out_last_r;
    dab_ctl.load        = 1'b0;
    dab_ctl.digit_shift = 1'b0;

    case (state_r)
      i2da_pkg::ST_IDLE: begin
        if (in_fire) begin
          dab_ctl.load = 1'b1;
          neg_nxt      = value[DATA_WIDTH-1];
          left_nxt     = LW'(ND);
          state_nxt    = i2da_pkg::ST_CONV;
        end
      end
      i2da_pkg::ST_CONV: begin
        if (!dab_busy) begin
          state_nxt = i2da_pkg::ST_SKIP;
        end
      end
      i2da_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == 4'd0 && left_r > LW'(1)) begin
          dab_ctl.digit_shift = 1'b1;
          left_nxt            = left_r - LW'(1);
        end else if (neg_r) begin
          state_nxt = i2da_pkg::ST_SIGN;
        end else begin
          state_nxt = i2da_pkg::ST_EMIT;
        end
      end
      i2da_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2da_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = i2da_pkg::ST_EMIT;
        end
      end
      i2da_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_char_nxt        = i2da_pkg::CHAR_ZERO + {4'b0000, top_digit};
          out_last_nxt        = (left_r == LW'(1));
          dab_ctl.digit_shift = 1'b1;
          left_nxt            = left_r - LW'(1);
          if (left_r == LW'(1)) begin
            state_nxt = i2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2da_pkg::ST_IDLE;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold until the next load
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/i2da_dabble.sv
`default_nettype none

// Bit-serial double dabble: while busy, one magnitude bit enters the BCD register per cycle
module i2da_dabble #(
  parameter int DATA_WIDTH = i2da_pkg::DATA_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  i2da_pkg::dab_ctl_t       ctl,
  input  wire  [DATA_WIDTH-1:0]    mag,
  output logic                     busy,
  output logic [3:0]               top_digit
);

  localparam int ND = i2da_pkg::digit_slots(DATA_WIDTH);
  localparam int BW = ND * 4;
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  logic [BW-1:0]         bcd_adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[d*4 +: 4] >= i2da_pkg::DABBLE_LIMIT) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + i2da_pkg::DABBLE_ADD;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.load) begin
      mag_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = CW'(DATA_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[DATA_WIDTH-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BW-2:0], mag_r[DATA_WIDTH-1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end else if (ctl.digit_shift) begin
      // advance to the next lower digit
      bcd_nxt = {bcd_r[BW-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy      = busy_r;
  assign top_digit = bcd_r[BW-1 -: 4];

endmodule

`default_nettype wire

FILE: rtl/i2da_checker.sv
`default_nettype none

module i2da_checker #(
  parameter  int DATA_WIDTH = i2da_pkg::DATA_WIDTH_DEF,
  localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8
) (
  input wire             clk,
  input wire             rst_n,
  input wire             in_tvalid,
  input wire             in_tready,
  input wire  [IN_W-1:0] in_tdata,
  input wire             out_tvalid,
  input wire             out_tready,
  input wire  [7:0]      out_tdata,
  input wire             out_tlast
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == i2da_pkg::CHAR_MINUS) ||
                   (out_tdata >= i2da_pkg::CHAR_ZERO && out_tdata <= i2da_pkg::CHAR_ZERO + 8'd9))
    else $error("character outside sign and digits");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == i2da_pkg::CHAR_MINUS |-> !out_tlast)
    else $error("sign flagged as final character");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new number accepted during conversion");

endmodule

bind int_to_decimal_ascii i2da_checker #(.DATA_WIDTH(DATA_WIDTH)) u_i2da_checker (.*);

`default_nettype wire
